// ===== design/tcr_pkg.sv =====
package tcr_pkg;

    // Output segments, emitted in index order by the back end
    localparam int NSEG  = 13;
    localparam int SEG_W = 4;
    localparam int OFF_W = 5;

    localparam logic [SEG_W-1:0] SEG_HDR     = 4'd0;
    localparam logic [SEG_W-1:0] SEG_LOPEN1  = 4'd1;
    localparam logic [SEG_W-1:0] SEG_PRE     = 4'd2;
    localparam logic [SEG_W-1:0] SEG_LCLOSE1 = 4'd3;
    localparam logic [SEG_W-1:0] SEG_EOPEN   = 4'd4;
    localparam logic [SEG_W-1:0] SEG_PAREN1  = 4'd5;
    localparam logic [SEG_W-1:0] SEG_LOPEN2  = 4'd6;
    localparam logic [SEG_W-1:0] SEG_CHAR    = 4'd7;
    localparam logic [SEG_W-1:0] SEG_FLUSH1  = 4'd8;
    localparam logic [SEG_W-1:0] SEG_FLUSH2  = 4'd9;
    localparam logic [SEG_W-1:0] SEG_LCLOSE2 = 4'd10;
    localparam logic [SEG_W-1:0] SEG_PAREN2  = 4'd11;
    localparam logic [SEG_W-1:0] SEG_NL      = 4'd12;

    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_QM   = 8'h3F;
    localparam logic [7:0] CH_EQ   = 8'h3D;
    localparam logic [7:0] CH_BANG = 8'h21;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_BSL  = 8'h5C;
    localparam logic [7:0] CH_DQ   = 8'h22;
    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_RPAR = 8'h29;

    localparam int HDR_LEN    = 32;
    localparam int LOPEN_LEN  = 10;
    localparam int LCLOSE_LEN = 2;
    localparam int EOPEN_LEN  = 9;

    localparam logic [8*HDR_LEN-1:0] HDR_TEXT =
        {";; ", 8'h45, 8'h53, 8'h43, 8'h4D, " translated part follows", CH_NL};
    localparam logic [8*LOPEN_LEN-1:0]  LOPEN_TEXT  = {"(display ", CH_DQ};
    localparam logic [8*LCLOSE_LEN-1:0] LCLOSE_TEXT = {CH_DQ, CH_RPAR};
    localparam logic [8*EOPEN_LEN-1:0]  EOPEN_TEXT  = "(display ";

    typedef struct packed {
        logic [NSEG-1:0] mask;
        logic [7:0]      ch;
        logic [7:0]      pre;
        logic [7:0]      flush;
    } cmd_t;

    typedef struct packed {
        logic not_empty;
        logic full;
    } qstat_t;

    function automatic logic [OFF_W:0] seg_len(input logic [SEG_W-1:0] seg);
        logic [OFF_W:0] len;
        unique case (seg)
            SEG_HDR:                  len = (OFF_W+1)'(HDR_LEN);
            SEG_LOPEN1, SEG_LOPEN2:   len = (OFF_W+1)'(LOPEN_LEN);
            SEG_LCLOSE1, SEG_LCLOSE2: len = (OFF_W+1)'(LCLOSE_LEN);
            SEG_EOPEN:                len = (OFF_W+1)'(EOPEN_LEN);
            default:                  len = (OFF_W+1)'(1);
        endcase
        return len;
    endfunction

    function automatic logic [7:0] seg_byte(input logic [SEG_W-1:0] seg,
                                            input logic [OFF_W-1:0] off,
                                            input cmd_t cmd);
        logic [7:0] b;
        unique case (seg)
            SEG_HDR:                  b = HDR_TEXT[8*(HDR_LEN-1-int'(off)) +: 8];
            SEG_LOPEN1, SEG_LOPEN2:   b = LOPEN_TEXT[8*(LOPEN_LEN-1-int'(off)) +: 8];
            SEG_LCLOSE1, SEG_LCLOSE2: b = LCLOSE_TEXT[8*(LCLOSE_LEN-1-int'(off)) +: 8];
            SEG_EOPEN:                b = EOPEN_TEXT[8*(EOPEN_LEN-1-int'(off)) +: 8];
            SEG_PRE:                  b = cmd.pre;
            SEG_CHAR:                 b = cmd.ch;
            SEG_FLUSH1:               b = cmd.flush;
            SEG_FLUSH2:               b = CH_QM;
            SEG_PAREN1, SEG_PAREN2:   b = CH_RPAR;
            SEG_NL:                   b = CH_NL;
            default:                  b = CH_NL;
        endcase
        return b;
    endfunction

endpackage

// ===== design/tcr_if.sv =====
interface tcr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_doc;

    modport source (output valid, output in_byte, output end_of_doc, input ready);
    modport sink (input valid, input in_byte, input end_of_doc, output ready);
endinterface

interface tcr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;

    modport source (output valid, output out_byte, output run_last, input ready);
    modport sink (input valid, input out_byte, input run_last, output ready);
endinterface

// ===== design/tcr_front.sv =====
module tcr_front (
    input  logic           clk,
    input  logic           rst_n,
    tcr_in_if.sink         doc,
    input  tcr_pkg::qstat_t q_stat,
    output tcr_pkg::cmd_t  cmd,
    output logic           push
);
    import tcr_pkg::*;

    typedef enum logic [2:0] {
        M_LIT,
        M_LIT_LT,
        M_LIT_LTQ,
        M_CODE,
        M_CODE_BG,
        M_EXPR,
        M_EXPR_BG
    } mode_t;

    mode_t mode_reg, mode_next, mode_mid;
    logic  hdr_reg, hdr_next;
    logic  accept;
    logic [7:0] c;

    assign doc.ready = !q_stat.full;
    assign accept    = doc.valid && !q_stat.full;
    assign c         = doc.in_byte;
    assign push      = accept && (cmd.mask != '0);

    always_comb
    begin
        cmd       = '0;
        cmd.ch    = c;
        mode_mid  = mode_reg;
        mode_next = mode_reg;
        hdr_next  = 1'b1;

        if (!hdr_reg)
        begin
            cmd.mask[SEG_HDR]    = 1'b1;
            cmd.mask[SEG_LOPEN1] = 1'b1;
        end

        unique case (mode_reg)
            M_LIT_LT:
            begin
                if (c == CH_QM)
                    mode_mid = M_LIT_LTQ;
                else
                begin
                    cmd.pre            = CH_LT;
                    cmd.mask[SEG_PRE]  = 1'b1;
                    cmd.mask[SEG_CHAR] = 1'b1;
                    mode_mid           = M_LIT;
                end
            end
            M_LIT_LTQ:
            begin
                cmd.mask[SEG_LCLOSE1] = 1'b1;
                if (c == CH_EQ)
                begin
                    cmd.mask[SEG_EOPEN] = 1'b1;
                    mode_mid            = M_EXPR;
                end
                else
                    mode_mid = M_CODE;
            end
            M_CODE, M_EXPR:
            begin
                if (c == CH_BANG)
                    mode_mid = (mode_reg == M_CODE) ? M_CODE_BG : M_EXPR_BG;
                else
                    cmd.mask[SEG_CHAR] = 1'b1;
            end
            M_CODE_BG, M_EXPR_BG:
            begin
                if (c == CH_GT)
                begin
                    cmd.pre              = CH_NL;
                    cmd.mask[SEG_PRE]    = 1'b1;
                    cmd.mask[SEG_PAREN1] = (mode_reg == M_EXPR_BG);
                    cmd.mask[SEG_LOPEN2] = 1'b1;
                    mode_mid             = M_LIT;
                end
                else
                begin
                    cmd.pre            = CH_BANG;
                    cmd.mask[SEG_PRE]  = 1'b1;
                    cmd.mask[SEG_CHAR] = 1'b1;
                    mode_mid           = (mode_reg == M_CODE_BG) ? M_CODE : M_EXPR;
                end
            end
            default:
            begin
                if (c == CH_LT)
                    mode_mid = M_LIT_LT;
                else
                begin
                    if (c == CH_DQ || c == CH_BSL)
                    begin
                        cmd.pre           = CH_BSL;
                        cmd.mask[SEG_PRE] = 1'b1;
                    end
                    cmd.mask[SEG_CHAR] = 1'b1;
                    mode_mid           = M_LIT;
                end
            end
        endcase

        mode_next = mode_mid;

        if (doc.end_of_doc)
        begin
            // flush a pending marker prefix, then close the open part
            unique case (mode_mid)
                M_LIT_LT:
                begin
                    cmd.flush            = CH_LT;
                    cmd.mask[SEG_FLUSH1] = 1'b1;
                    cmd.mask[SEG_LCLOSE2] = 1'b1;
                end
                M_LIT_LTQ:
                begin
                    cmd.flush             = CH_LT;
                    cmd.mask[SEG_FLUSH1]  = 1'b1;
                    cmd.mask[SEG_FLUSH2]  = 1'b1;
                    cmd.mask[SEG_LCLOSE2] = 1'b1;
                end
                M_CODE_BG:
                begin
                    cmd.flush            = CH_BANG;
                    cmd.mask[SEG_FLUSH1] = 1'b1;
                end
                M_EXPR_BG:
                begin
                    cmd.flush            = CH_BANG;
                    cmd.mask[SEG_FLUSH1] = 1'b1;
                    cmd.mask[SEG_PAREN2] = 1'b1;
                end
                M_EXPR:
                    cmd.mask[SEG_PAREN2] = 1'b1;
                M_CODE:
                    cmd.mask[SEG_NL] = 1'b1;
                default:
                    cmd.mask[SEG_LCLOSE2] = 1'b1;
            endcase
            cmd.mask[SEG_NL] = 1'b1;
            mode_next        = M_LIT;
            hdr_next         = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_LIT;
            hdr_reg  <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            hdr_reg  <= hdr_next;
        end
    end

endmodule

// ===== design/tcr_queue.sv =====
module tcr_queue #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tcr_pkg::cmd_t   wr_data,
    input  logic            pop,
    output tcr_pkg::cmd_t   rd_data,
    output tcr_pkg::qstat_t stat
);
    import tcr_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign stat.full      = (count_reg == CNT_W'(DEPTH));
    assign stat.not_empty = (count_reg != '0);
    assign rd_data        = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== design/tcr_back.sv =====
module tcr_back (
    input  logic            clk,
    input  logic            rst_n,
    input  tcr_pkg::cmd_t   q_data,
    input  tcr_pkg::qstat_t q_stat,
    output logic            pop,
    tcr_out_if.source       code
);
    import tcr_pkg::*;

    cmd_t             cur_reg;
    logic             cur_valid_reg;
    logic [OFF_W-1:0] off_reg;
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             out_last_reg;

    logic [SEG_W-1:0] seg;
    logic [NSEG-1:0]  mask_after;
    logic             adv, seg_done, fin;

    assign code.valid    = out_valid_reg;
    assign code.out_byte = out_byte_reg;
    assign code.run_last = out_last_reg;

    // lowest pending segment goes first
    always_comb
    begin
        seg = '0;
        for (int i = NSEG - 1; i >= 0; i--)
        begin
            if (cur_reg.mask[i])
                seg = SEG_W'(i);
        end
    end

    assign adv        = cur_valid_reg && (!out_valid_reg || code.ready);
    assign seg_done   = ((OFF_W+1)'(off_reg) + 1'b1) == seg_len(seg);
    assign mask_after = cur_reg.mask & ~(NSEG'(1) << seg);
    assign fin        = adv && seg_done && (mask_after == '0);
    assign pop        = (!cur_valid_reg || fin) && q_stat.not_empty;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= q_data;
            off_reg <= '0;
        end
        else if (adv)
        begin
            if (seg_done)
            begin
                cur_reg.mask <= mask_after;
                off_reg      <= '0;
            end
            else
                off_reg <= off_reg + 1'b1;
        end
        if (adv)
        begin
            out_byte_reg <= seg_byte(seg, off_reg, cur_reg);
            out_last_reg <= seg_done && (mask_after == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
                cur_valid_reg <= 1'b1;
            else if (fin)
                cur_valid_reg <= 1'b0;
            if (adv)
                out_valid_reg <= 1'b1;
            else if (code.ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

// ===== design/template_to_code_rewriter.sv =====
// A request's first output byte passes through the command queue, the current-command
// register and the output register. Throughput: one output byte per cycle while the sink
// is ready; a request makes 0 to 47 bytes, all sent through the single output byte port.
// Input requests enter every cycle while the command queue (QUEUE_DEPTH entries) has room.
// Reset (rst_n low, asynchronous) returns to literal mode with the header pending and
// empties the queue and the output register.
module template_to_code_rewriter #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    tcr_in_if.sink    doc,
    tcr_out_if.source code
);
    import tcr_pkg::*;

    cmd_t   f_cmd, q_cmd;
    qstat_t q_stat;
    logic   q_push, q_pop;

    tcr_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .doc    (doc),
        .q_stat (q_stat),
        .cmd    (f_cmd),
        .push   (q_push)
    );

    tcr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (f_cmd),
        .pop     (q_pop),
        .rd_data (q_cmd),
        .stat    (q_stat)
    );

    tcr_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_data (q_cmd),
        .q_stat (q_stat),
        .pop    (q_pop),
        .code   (code)
    );

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_stat.not_empty)
        else $error("back end popped an empty queue");

    a_push_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (f_cmd.mask != '0))
        else $error("front end queued a command with no output");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && !q_pop) |=> q_stat.not_empty)
        else $error("queued command lost");

    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> !q_push)
        else $error("push into a full queue");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import tcr_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 7;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_ITEMS = 40;
    localparam int NUM_PHASES   = 4;

    typedef enum logic [2:0] {
        ST_LIT       = 3'd0,
        ST_LIT_LT    = 3'd1,
        ST_LIT_LTQ   = 3'd2,
        ST_CODE      = 3'd3,
        ST_CODE_BANG = 3'd4,
        ST_EXPR      = 3'd5,
        ST_EXPR_BANG = 3'd6
    } doc_mode_t;

    typedef struct {
        logic [7:0] b;
        logic       eod;
    } doc_item_t;

    typedef struct {
        logic [7:0] b;
        logic       last;
    } code_item_t;

    localparam logic [7:0] MARK_BYTES [7] = '{CH_LT, CH_QM, CH_EQ, CH_BANG, CH_GT, CH_DQ, CH_BSL};
    localparam int SRC_IDLE  [NUM_PHASES] = '{0, 55, 0, 19};
    localparam int SINK_IDLE [NUM_PHASES] = '{0, 0, 55, 19};

    logic clk   = 1'b0;
    logic rst_n = 1'b1;

    tcr_in_if  doc_if ();
    tcr_out_if code_if ();

    template_to_code_rewriter DUT (
        .clk  (clk),
        .rst_n(rst_n),
        .doc  (doc_if),
        .code (code_if)
    );

    always #(CLK_HALF) clk = ~clk;

    doc_item_t  template_q [$];
    code_item_t code_q [$];
    logic [7:0] step_bytes [$];

    doc_mode_t doc_mode   = ST_LIT;
    logic      header_due = 1'b1;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    function automatic void emit(input logic [7:0] b);
        step_bytes.push_back(b);
    endfunction

    function automatic void emit_text(input string s);
        for (int i = 0; i < s.len(); i++)
            emit(s[i]);
    endfunction

    // Expected code bytes for one accepted template byte
    function automatic void rewrite_byte(input logic [7:0] c, input logic eod);
        code_item_t ci;
        step_bytes.delete();
        if (header_due)
        begin
            emit_text(";; ");
            emit(8'h45);
            emit(8'h53);
            emit(8'h43);
            emit(8'h4D);
            emit_text(" translated part follows\n");
            emit_text("(display \"");
            header_due = 1'b0;
        end
        case (doc_mode)
            ST_LIT_LT:
            begin
                if (c == CH_QM)
                    doc_mode = ST_LIT_LTQ;
                else
                begin
                    emit(CH_LT);
                    emit(c);
                    doc_mode = ST_LIT;
                end
            end
            ST_LIT_LTQ:
            begin
                emit_text("\")");
                if (c == CH_EQ)
                begin
                    emit_text("(display ");
                    doc_mode = ST_EXPR;
                end
                else
                    doc_mode = ST_CODE;
            end
            ST_CODE, ST_EXPR:
            begin
                if (c == CH_BANG)
                    doc_mode = (doc_mode == ST_CODE) ? ST_CODE_BANG : ST_EXPR_BANG;
                else
                    emit(c);
            end
            ST_CODE_BANG, ST_EXPR_BANG:
            begin
                if (c == CH_GT)
                begin
                    emit(CH_NL);
                    if (doc_mode == ST_EXPR_BANG)
                        emit(CH_RPAR);
                    emit_text("(display \"");
                    doc_mode = ST_LIT;
                end
                else
                begin
                    emit(CH_BANG);
                    emit(c);
                    doc_mode = (doc_mode == ST_CODE_BANG) ? ST_CODE : ST_EXPR;
                end
            end
            default:
            begin
                if (c == CH_LT)
                    doc_mode = ST_LIT_LT;
                else
                begin
                    if (c == CH_DQ || c == CH_BSL)
                        emit(CH_BSL);
                    emit(c);
                    doc_mode = ST_LIT;
                end
            end
        endcase
        if (eod)
        begin
            // flush a dangling marker prefix, then close the current part
            if (doc_mode == ST_LIT_LT)
            begin
                emit(CH_LT);
                doc_mode = ST_LIT;
            end
            else if (doc_mode == ST_LIT_LTQ)
            begin
                emit(CH_LT);
                emit(CH_QM);
                doc_mode = ST_LIT;
            end
            else if (doc_mode == ST_CODE_BANG || doc_mode == ST_EXPR_BANG)
            begin
                emit(CH_BANG);
                doc_mode = (doc_mode == ST_CODE_BANG) ? ST_CODE : ST_EXPR;
            end
            if (doc_mode == ST_LIT)
                emit_text("\")");
            else if (doc_mode == ST_EXPR)
                emit(CH_RPAR);
            emit(CH_NL);
            doc_mode   = ST_LIT;
            header_due = 1'b1;
        end
        for (int i = 0; i < step_bytes.size(); i++)
        begin
            ci.b    = step_bytes[i];
            ci.last = (i == step_bytes.size() - 1);
            code_q.push_back(ci);
        end
    endfunction

    function automatic void push_byte(input logic [7:0] b);
        doc_item_t it;
        it.b   = b;
        it.eod = 1'b0;
        template_q.push_back(it);
    endfunction

    function automatic void feed_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endfunction

    function automatic void close_doc();
        doc_item_t it;
        it     = template_q.pop_back();
        it.eod = 1'b1;
        template_q.push_back(it);
    endfunction

    function automatic void push_body();
        int n;
        n = $urandom_range(0, 5);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 4) == 0)
                push_byte(CH_BANG);
            else
                push_byte(8'($urandom_range(0, 255)));
        end
    endfunction

    // Mostly well-formed parts with random content, some stray and unclosed markers
    function automatic void make_doc();
        int n_tok;
        n_tok = $urandom_range(1, 8);
        for (int t = 0; t < n_tok; t++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: push_byte(8'($urandom_range(0, 255)));
                3:       push_byte(MARK_BYTES[$urandom_range(0, 6)]);
                4, 5, 6, 7:
                begin
                    push_byte(CH_LT);
                    push_byte(CH_QM);
                    if ($urandom_range(0, 1) == 0)
                        push_byte(CH_EQ);
                    else
                        push_byte(8'($urandom_range(0, 255)));
                    push_body();
                    if ($urandom_range(0, 9) != 0)
                    begin
                        push_byte(CH_BANG);
                        push_byte(CH_GT);
                    end
                end
                8:
                begin
                    push_byte(CH_LT);
                    push_byte(8'($urandom_range(0, 255)));
                end
                default:
                begin
                    push_byte(CH_BANG);
                    push_byte(8'($urandom_range(0, 255)));
                end
            endcase
        end
        close_doc();
    endfunction

    function automatic void add_random_docs(input int n_items);
        int start;
        start = template_q.size();
        while (template_q.size() - start < n_items)
            make_doc();
    endfunction

    function automatic void load_directed();
        push_byte(8'hFF);
        push_byte(CH_DQ);
        push_byte(CH_BSL);
        feed_text("<x<?=!q!><? ");
        push_byte(8'h00);
        close_doc();
        feed_text("<");
        close_doc();
        feed_text("<?");
        close_doc();
        feed_text("<?=!");
        close_doc();
        feed_text("<?.!");
        close_doc();
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : drive_doc
        doc_item_t it;
        if (!rst_n)
        begin
            doc_if.valid      <= 1'b0;
            doc_if.in_byte    <= 8'h00;
            doc_if.end_of_doc <= 1'b0;
        end
        else
        begin
            if (doc_if.valid && doc_if.ready)
                rewrite_byte(doc_if.in_byte, doc_if.end_of_doc);
            if (!doc_if.valid || doc_if.ready)
            begin
                if (template_q.size() > 0 && $urandom_range(0, 99) >= src_idle_pct)
                begin
                    it = template_q.pop_front();
                    doc_if.valid      <= 1'b1;
                    doc_if.in_byte    <= it.b;
                    doc_if.end_of_doc <= it.eod;
                end
                else
                    doc_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : check_code
        code_item_t exp_item;
        if (!rst_n)
            code_if.ready <= 1'b0;
        else
        begin
            if (code_if.valid && code_if.ready)
            begin
                if (code_q.size() == 0)
                begin
                    $display("%0t: code byte expected none actual %02h run_last %0b",
                             $time, code_if.out_byte, code_if.run_last);
                    mismatch_count++;
                end
                else
                begin
                    exp_item = code_q.pop_front();
                    if (code_if.out_byte !== exp_item.b)
                    begin
                        $display("%0t: out_byte expected %02h actual %02h",
                                 $time, exp_item.b, code_if.out_byte);
                        mismatch_count++;
                    end
                    if (code_if.run_last !== exp_item.last)
                    begin
                        $display("%0t: run_last expected %0b actual %0b",
                                 $time, exp_item.last, code_if.run_last);
                        mismatch_count++;
                    end
                end
            end
            code_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[template_to_code_rewriter] ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            @(negedge clk);
            src_idle_pct   = SRC_IDLE[p];
            sink_stall_pct = SINK_IDLE[p];
            if (p == 0)
                load_directed();
            add_random_docs(RANDOM_ITEMS);
            // drain before the next idle mix
            while (template_q.size() > 0 || doc_if.valid || code_q.size() > 0)
                @(negedge clk);
        end
        repeat (20) @(negedge clk);
        if (mismatch_count == 0 && code_q.size() == 0)
            $display("[template_to_code_rewriter] OK");
        else
            $display("[template_to_code_rewriter] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/tcr_pkg.sv
design/tcr_if.sv
design/tcr_front.sv
design/tcr_queue.sv
design/tcr_back.sv
design/template_to_code_rewriter.sv
test/testbench.sv
